/* rtl/tlm_pkg.sv */
// ----------------------------------------------------------------------------
// tlm_pkg
// Shared types and constants for the track lifecycle manager and its checker.
// ----------------------------------------------------------------------------
package tlm_pkg;

	localparam int COUNT_BITS_DEF = 16;

	localparam int HIT_GOAL_W = 8;
	localparam int LIMIT_W    = 14;
	localparam int CFG_DATA_W = 14;
	localparam int CFG_IDX_W  = 1;
	localparam int OP_W       = 2;
	localparam int COORD_W    = 16;
	localparam int SIZE_W     = 15;
	localparam int OUT_CNT_W  = 16;
	localparam int TS_W       = 2;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 40;

	localparam logic [HIT_GOAL_W-1:0] HIT_GOAL_RST = 8'd2;
	localparam logic [LIMIT_W-1:0]    LIMIT_RST    = 14'd25;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HIT_GOAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 1'd1;

	// event codes carried on tuser
	typedef enum logic [OP_W-1:0] {
		OP_INIT    = 2'd0,
		OP_PREDICT = 2'd1,
		OP_UPDATE  = 2'd2
	} op_t;

	// reported track state codes
	localparam logic [TS_W-1:0] TS_PROVISIONAL = 2'd0;
	localparam logic [TS_W-1:0] TS_ACTIVE      = 2'd1;
	localparam logic [TS_W-1:0] TS_LOST        = 2'd2;

	// internal lifecycle state, one-hot
	typedef enum logic [2:0] {
		LIFE_PROVISIONAL = 3'b001,
		LIFE_ACTIVE      = 3'b010,
		LIFE_LOST        = 3'b100
	} life_t;

endpackage

/* rtl/track_lifecycle_manager.sv */
// ----------------------------------------------------------------------------
// track_lifecycle_manager
// Lifecycle state of one object track, driven by init, predict and update events.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_*       | in        | tuser: operation[1:0]; tdata: box_x, box_y, box_width, box_height
//  m_*       | out       | tdata: track_state, is_active, coast_count, streak_count
//  cfg_*     | in        | write only: 0 hit goal, 1 stationary_limit
//
//  one event per clock sustained while m_tready is high; a result is presented from the result
//  register (input register feeds the result register)
//  all state updates for an event happen in the cycle it leaves the input register
//  arst_n clears counters, previous box and config to their defaults
//  a stalled result register still lets one more event wait in the input register
module track_lifecycle_manager
	import tlm_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [OP_W-1:0]       s_tuser,  // operation[1:0]
	input  logic [IN_DATA_W-1:0]  s_tdata,  // box_x[15:0], box_y[31:16], box_width[46:32],
	                                        // box_height[61:47], zero[63:62]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // track_state[1:0], is_active[2], coast_count[18:3],
	                                        // streak_count[34:19], zero[39:35]
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CMP_W = (COUNT_BITS > LIMIT_W + 1) ? COUNT_BITS : LIMIT_W + 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	// configuration
	logic [HIT_GOAL_W-1:0] hit_goal_q;
	logic [LIMIT_W-1:0]    limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_goal_q <= HIT_GOAL_RST;
			limit_q    <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HIT_GOAL: hit_goal_q <= cfg_wdata[HIT_GOAL_W-1:0];
				CFG_LIMIT:    limit_q    <= cfg_wdata[LIMIT_W-1:0];
				default:      ;
			endcase
		end
	end

	// input register
	logic               valid_s1;
	logic [OP_W-1:0]    op_s1;
	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] y_s1;
	logic [SIZE_W-1:0]  w_s1;
	logic [SIZE_W-1:0]  h_s1;
	logic               advance;
	logic               out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= s_tuser;
			x_s1  <= s_tdata[15:0];
			y_s1  <= s_tdata[31:16];
			w_s1  <= s_tdata[46:32];
			h_s1  <= s_tdata[61:47];
		end
	end

	// track state
	life_t                 life_q;
	logic [COUNT_BITS-1:0] coast_q;
	logic [COUNT_BITS-1:0] hit_q;
	logic [COUNT_BITS-1:0] still_q;
	logic [COORD_W-1:0]    prev_x_q;
	logic [COORD_W-1:0]    prev_y_q;
	logic [SIZE_W-1:0]     prev_w_q;
	logic [SIZE_W-1:0]     prev_h_q;

	life_t                 life_d;
	logic [COUNT_BITS-1:0] coast_d;
	logic [COUNT_BITS-1:0] hit_d;
	logic [COUNT_BITS-1:0] still_d;
	logic                  load_box;

	// overlap of previous box and incoming box, inclusive edges
	logic signed [COORD_W:0] ax, ay, bx, by, ax_end, ay_end, bx_end, by_end;
	logic                    overlap;

	always_comb begin
		ax     = $signed({prev_x_q[COORD_W-1], prev_x_q});
		ay     = $signed({prev_y_q[COORD_W-1], prev_y_q});
		bx     = $signed({x_s1[COORD_W-1], x_s1});
		by     = $signed({y_s1[COORD_W-1], y_s1});
		ax_end = ax + $signed({2'b00, prev_w_q});
		ay_end = ay + $signed({2'b00, prev_h_q});
		bx_end = bx + $signed({2'b00, w_s1});
		by_end = by + $signed({2'b00, h_s1});
		overlap = (prev_w_q != '0) && (prev_h_q != '0) && (w_s1 != '0) && (h_s1 != '0)
			&& !(ax > bx_end) && !(bx > ax_end)
			&& !(ay > by_end) && !(by > ay_end);
	end

	logic [COUNT_BITS-1:0] coast_inc, hit_inc, still_inc;
	logic [LIMIT_W:0]      upper;
	logic [CMP_W-1:0]      still_ext;
	logic                  in_window;
	logic                  hit_ok_pred, hit_ok_upd;

	assign coast_inc = (coast_q == CNT_MAX) ? coast_q : coast_q + 1'b1;
	assign hit_inc   = (hit_q == CNT_MAX) ? hit_q : hit_q + 1'b1;
	assign still_inc = (still_q == CNT_MAX) ? still_q : still_q + 1'b1;
	assign upper     = {1'b0, limit_q} + {2'b00, limit_q[LIMIT_W-1:1]};

	assign hit_ok_pred = hit_q >= COUNT_BITS'(hit_goal_q);
	assign hit_ok_upd  = hit_inc >= COUNT_BITS'(hit_goal_q);

	always_comb begin
		life_d    = life_q;
		coast_d   = coast_q;
		hit_d     = hit_q;
		still_d   = still_q;
		load_box  = 1'b0;
		still_ext = '0;
		in_window = 1'b0;
		unique case (op_s1)
			OP_INIT: begin
				hit_d = hit_inc;
			end
			OP_PREDICT: begin
				if (coast_q != '0) begin
					hit_d  = '0;
					life_d = LIFE_LOST;
				end else if (hit_ok_pred) begin
					life_d = LIFE_ACTIVE;
				end else begin
					life_d = LIFE_PROVISIONAL;
				end
				coast_d   = coast_inc;
				still_d   = overlap ? '0 : still_inc;
				still_ext = CMP_W'(still_d);
				in_window = (still_ext >= CMP_W'(limit_q)) && (still_ext < CMP_W'(upper));
				if (in_window) begin
					life_d = LIFE_LOST;
				end
				load_box = 1'b1;
			end
			OP_UPDATE: begin
				coast_d = '0;
				hit_d   = hit_inc;
				if (hit_ok_upd) begin
					life_d = LIFE_ACTIVE;
				end
				still_d  = '0;
				load_box = 1'b1;
			end
			default: ;  // unused code leaves the state alone
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q   <= LIFE_PROVISIONAL;
			coast_q  <= '0;
			hit_q    <= '0;
			still_q  <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_w_q <= '0;
			prev_h_q <= '0;
		end else if (advance) begin
			life_q  <= life_d;
			coast_q <= coast_d;
			hit_q   <= hit_d;
			still_q <= still_d;
			if (load_box) begin
				prev_x_q <= x_s1;
				prev_y_q <= y_s1;
				prev_w_q <= w_s1;
				prev_h_q <= h_s1;
			end
		end
	end

	// result register
	logic [TS_W-1:0]                  ts_d;
	logic [OUT_CNT_W+COUNT_BITS-1:0]  coast_wide, hit_wide;
	logic [OUT_DATA_W-1:0]            out_data_q;

	always_comb begin
		unique case (life_d)
			LIFE_PROVISIONAL: ts_d = TS_PROVISIONAL;
			LIFE_ACTIVE:      ts_d = TS_ACTIVE;
			LIFE_LOST:        ts_d = TS_LOST;
			default:          ts_d = TS_PROVISIONAL;
		endcase
	end

	assign coast_wide = {{OUT_CNT_W{1'b0}}, coast_d};
	assign hit_wide   = {{OUT_CNT_W{1'b0}}, hit_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {5'b00000, hit_wide[OUT_CNT_W-1:0], coast_wide[OUT_CNT_W-1:0],
				(life_d == LIFE_ACTIVE), ts_d};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

/* rtl/tlm_checker.sv */
// ----------------------------------------------------------------------------
// tlm_checker
// Port-level checks for the track lifecycle manager, bound to the top level.
// ----------------------------------------------------------------------------
module tlm_checker
	import tlm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// the active flag follows the reported state
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2] == (m_tdata[1:0] == TS_ACTIVE)))
		else $error("is_active disagrees with track_state");

	// with no pending result the block must take a new transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// zero padding above the result fields
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[39:35] == 5'b00000))
		else $error("result padding not zero");

endmodule

bind track_lifecycle_manager tlm_checker u_tlm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives init, predict and update events into the track lifecycle manager,
// predicts each reported track state in step with the design and compares
// every result field. Config is changed between phases while the design is
// idle; both stream sides idle at random and the result side holds off for a
// long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module testbench;
	import tlm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int CHUNK_EVENTS = 140;
	localparam int HOLD_CYCLES = 250;

	// the design ignores this event code and just reports the current state
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [SIZE_W-1:0]  w;
		logic [SIZE_W-1:0]  h;
	} track_event_t;

	typedef struct {
		logic [TS_W-1:0]      state;
		logic                 active;
		logic [OUT_CNT_W-1:0] coast;
		logic [OUT_CNT_W-1:0] streak;
	} track_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [OP_W-1:0] s_tuser = '0;        // operation[1:0]
	logic [IN_DATA_W-1:0] s_tdata = '0;   // box_x, box_y, box_width, box_height, zero pad
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;       // track_state, is_active, coast_count, streak_count
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	track_event_t event_queue[$];
	track_report_t expected_reports[$];
	track_event_t cur_event;

	int fail_count = 0;
	int cycle_count = 0;
	int results_seen = 0;
	int queued_count = 0;
	int holds_done = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	// predicted track state and config
	logic [HIT_GOAL_W-1:0] hit_goal_cfg = HIT_GOAL_RST;
	logic [LIMIT_W-1:0] still_limit_cfg = LIMIT_RST;
	logic [TS_W-1:0] trk_state = TS_PROVISIONAL;
	logic [OUT_CNT_W-1:0] coast_cnt = '0;
	logic [OUT_CNT_W-1:0] hit_cnt = '0;
	logic [OUT_CNT_W-1:0] still_cnt = '0;
	int prev_x = 0;
	int prev_y = 0;
	int prev_w = 0;
	int prev_h = 0;

	// anchor for boxes that wander around a track position
	shortint near_x = 0;
	shortint near_y = 0;

	track_lifecycle_manager #(
		.COUNT_BITS(COUNT_BITS_DEF)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic track_report_t apply_event(track_event_t ev);
		int bx;
		int by;
		int bw;
		int bh;
		int upper;
		bit touch;
		track_report_t rep;
		bx = int'($signed(ev.x));
		by = int'($signed(ev.y));
		bw = int'(ev.w);
		bh = int'(ev.h);
		case (ev.op)
			OP_INIT: begin
				if (hit_cnt != '1) hit_cnt++;
			end
			OP_PREDICT: begin
				upper = int'(still_limit_cfg) + int'(still_limit_cfg >> 1);
				if (coast_cnt != 0) begin
					hit_cnt = '0;
					trk_state = TS_LOST;
				end else if (hit_cnt >= hit_goal_cfg) begin
					trk_state = TS_ACTIVE;
				end else begin
					trk_state = TS_PROVISIONAL;
				end
				if (coast_cnt != '1) coast_cnt++;
				// inclusive edges, empty boxes never overlap
				touch = prev_w != 0 && prev_h != 0 && bw != 0 && bh != 0 &&
					!(prev_x > bx + bw || bx > prev_x + prev_w) &&
					!(prev_y > by + bh || by > prev_y + prev_h);
				if (touch) still_cnt = '0;
				else if (still_cnt != '1) still_cnt++;
				if (int'(still_cnt) >= int'(still_limit_cfg) && int'(still_cnt) < upper)
					trk_state = TS_LOST;
				prev_x = bx;
				prev_y = by;
				prev_w = bw;
				prev_h = bh;
			end
			OP_UPDATE: begin
				coast_cnt = '0;
				if (hit_cnt != '1) hit_cnt++;
				if (hit_cnt >= hit_goal_cfg) trk_state = TS_ACTIVE;
				still_cnt = '0;
				prev_x = bx;
				prev_y = by;
				prev_w = bw;
				prev_h = bh;
			end
			default: begin
			end
		endcase
		rep.state = trk_state;
		rep.active = (trk_state == TS_ACTIVE);
		rep.coast = coast_cnt;
		rep.streak = hit_cnt;
		return rep;
	endfunction

	task automatic queue_event(input logic [OP_W-1:0] op, input int x, input int y,
			input int w, input int h);
		track_event_t ev;
		ev.op = op;
		ev.x = x[COORD_W-1:0];
		ev.y = y[COORD_W-1:0];
		ev.w = w[SIZE_W-1:0];
		ev.h = h[SIZE_W-1:0];
		event_queue = {event_queue, ev};
		queued_count++;
	endtask

	task automatic queue_random(input logic [OP_W-1:0] op);
		int kind;
		int x;
		int y;
		int w;
		int h;
		kind = $urandom_range(0, 15);
		if (kind == 0) begin
			x = int'($urandom_range(0, 65535)) - 32768;
			y = int'($urandom_range(0, 65535)) - 32768;
			w = $urandom_range(0, 32767);
			h = $urandom_range(0, 32767);
		end else if (kind == 1) begin
			x = $urandom_range(0, 1) ? -32768 : 32767;
			y = $urandom_range(0, 1) ? -32768 : 32767;
			w = $urandom_range(0, 1) ? 32767 : 0;
			h = $urandom_range(0, 1) ? 32767 : 0;
		end else begin
			x = int'(near_x) + int'($urandom_range(0, 160)) - 80;
			y = int'(near_y) + int'($urandom_range(0, 160)) - 80;
			w = $urandom_range(1, 64);
			h = $urandom_range(1, 64);
			if (kind == 2) begin
				if ($urandom_range(0, 1)) w = 0;
				else h = 0;
			end
		end
		near_x = shortint'(x);
		near_y = shortint'(y);
		queue_event(op, x, y, w, h);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_HIT_GOAL) hit_goal_cfg = value[HIT_GOAL_W-1:0];
		else still_limit_cfg = value[LIMIT_W-1:0];
	endtask

	// every queued event must have come back as a result transaction
	task automatic wait_idle();
		while (results_seen < queued_count || s_tvalid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// event source
	always @(posedge clk or negedge arst_n) begin : tx_side
		logic busy;
		track_report_t rep;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left = 0;
		end else begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				rep = apply_event(cur_event);
				expected_reports = {expected_reports, rep};
				busy = 1'b0;
			end
			if (!busy) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (event_queue.size() > 0) begin
					cur_event = event_queue.pop_front();
					s_tuser <= cur_event.op;
					s_tdata <= {2'b00, cur_event.h, cur_event.w, cur_event.y, cur_event.x};
					busy = 1'b1;
					if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
					gap_left = tx_calm ? 0 : $urandom_range(0, 12);
				end
			end
			s_tvalid <= busy;
		end
	end

	// result sink and checker
	always @(posedge clk or negedge arst_n) begin : rx_side
		track_report_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_reports.size() == 0) begin
					$error("result transaction with nothing expected: %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					if (m_tdata[1:0] !== want.state) begin
						$error("track_state: expected %0d, actual %0d", want.state, m_tdata[1:0]);
						fail_count++;
					end
					if (m_tdata[2] !== want.active) begin
						$error("is_active: expected %0d, actual %0d", want.active, m_tdata[2]);
						fail_count++;
					end
					if (m_tdata[18:3] !== want.coast) begin
						$error("coast_count: expected %0d, actual %0d", want.coast, m_tdata[18:3]);
						fail_count++;
					end
					if (m_tdata[34:19] !== want.streak) begin
						$error("streak_count: expected %0d, actual %0d", want.streak,
							m_tdata[34:19]);
						fail_count++;
					end
				end
				if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
				stall_left = rx_calm ? 0 : $urandom_range(0, 12);
			end else if (hold_left > 0) begin
				hold_left--;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			// long back-pressure while plenty of events are still waiting
			if (hold_left == 0 && holds_done < 2 && results_seen >= 200 * (holds_done + 1) &&
					event_queue.size() > 100) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			m_tready <= (hold_left == 0 && stall_left == 0);
		end
	end

	initial begin : stimulus
		int unsigned hit_plan[8];
		int unsigned limit_plan[8];
		int pick;
		logic [OP_W-1:0] op;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// default config
		queue_event(OP_PREDICT, 0, 0, 10, 10);               // reset box never overlaps
		queue_event(OP_PREDICT, 5, 5, 10, 10);               // coasting goes lost
		queue_event(OP_INIT, -1, -1, 7, 7);
		queue_event(OP_UPDATE, -32768, -32768, 0, 0);
		queue_event(OP_PREDICT, -32768, -32768, 0, 0);       // empty boxes
		queue_event(OP_UNUSED, 32767, 32767, 32767, 32767);
		queue_event(OP_UPDATE, 32767, 32767, 32767, 32767);
		queue_event(OP_PREDICT, 32767, 32767, 32767, 32767);
		queue_event(OP_UPDATE, 100, 100, 20, 20);
		queue_event(OP_PREDICT, 120, 120, 5, 5);             // touching corner counts
		queue_event(OP_UPDATE, 100, 100, 20, 20);
		queue_event(OP_PREDICT, 121, 100, 5, 5);             // one pixel apart
		queue_event(OP_PREDICT, 0, 0, 32767, 0);
		queue_event(OP_UPDATE, -1, -1, 1, 1);                // streak still below the hit goal
		queue_event(OP_UPDATE, 0, 0, 1, 1);
		queue_event(OP_INIT, -32768, 32767, 32767, 0);
		queue_event(OP_PREDICT, -2, -2, 1, 1);
		queue_event(OP_UPDATE, 0, -32768, 0, 32767);
		queue_event(OP_PREDICT, 0, -32768, 0, 32767);
		queue_event(OP_UNUSED, 0, 0, 0, 0);
		queue_event(OP_INIT, 0, 0, 0, 0);
		wait_idle();

		hit_plan = '{0, 255, 1, 3, 2, $urandom_range(0, 6), $urandom_range(0, 255), 5};
		limit_plan = '{0, 16383, 1, 2, 3, $urandom_range(0, 10), $urandom_range(0, 16383), 7};
		for (int p = 0; p < 8; p++) begin
			write_reg(CFG_HIT_GOAL, hit_plan[p]);
			write_reg(CFG_LIMIT, limit_plan[p]);
			for (int k = 0; k < CHUNK_EVENTS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) op = OP_PREDICT;
				else if (pick < 80) op = OP_UPDATE;
				else if (pick < 93) op = OP_INIT;
				else op = OP_UNUSED;
				queue_random(op);
			end
			wait_idle();
		end

		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/tlm_pkg.sv
rtl/track_lifecycle_manager.sv
rtl/tlm_checker.sv
sim/testbench.sv
